// ----- src/hmac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hmac_pkg;
    localparam int KeyWords = 8;
    localparam int AddrWidth = 6;
    localparam logic [31:0] IPAD = 32'h36363636;
    localparam logic [31:0] OPAD = 32'h5c5c5c5c;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    // what the current compression is for
    typedef enum logic [2:0] {
        JOB_IPAD,
        JOB_DATA,
        JOB_PAD,
        JOB_OPAD,
        JOB_OUTER
    } job_t;

    typedef logic [31:0] word_t;

    function automatic word_t init_h(input logic [2:0] i);
        word_t r;
        r = 32'h0;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        word_t r;
        r = 32'h0;
        case (i)
            6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
            6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
            6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
            6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
            6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
            6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
            6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
            6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
            6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
            6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
            6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
            6'd63: r = 32'hc67178f2;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ----- src/hmac_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface hmac_in_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic byte_present;
    logic message_end;
    modport source (output valid, data_byte, byte_present, message_end, input ready);
    modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface hmac_out_if;
    logic valid;
    logic ready;
    logic [63:0] tag_word;
    logic tag_last;
    modport source (output valid, tag_word, tag_last, input ready);
    modport sink (input valid, tag_word, tag_last, output ready);
endinterface
`default_nettype wire

// ----- src/hmac_sha256_stream_core.sv -----
// hmac-sha256 over a byte stream
// in channel: one item carries data_byte, byte_present and message_end; an item with
// byte_present and message_end both low is dropped at once
// out channel: four 64-bit tag words per message, tag bytes 0..7 first, tag_last on
// the fourth
// apb port: key_word_0..7 at byte addresses 0, 8, .. 56; write only while idle
// one shared sha-256 round unit does one round per cycle; a compression is a load step,
// 64 rounds and a final add step
// a byte that does not complete a block is taken while idle; the first item of a message
// also runs the ipad block, merging its byte in the final add step, and then a pad step;
// the 64th byte of a block runs a compression
// message_end costs a pad step, one or two padding compressions plus opad and outer
// blocks, then the four tag words
// in.ready is low during every compression and while tag words are held
// when the receiver stalls the current tag word holds and no new item is taken
// reset returns to idle with no message open; the key registers clear to zero
`timescale 1ns / 1ps
`default_nettype none
module hmac_sha256_stream_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    hmac_in_if.sink          in_ch,
    hmac_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [hmac_pkg::AddrWidth-1:0] paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import hmac_pkg::*;

    logic [63:0] key_reg [KeyWords];
    word_t hash_reg [8];
    word_t hash_next [8];
    word_t var_reg [8];
    word_t w_reg [16];
    word_t blk_reg [16];
    word_t inner_reg [8];
    logic [5:0] fill_reg;
    logic [63:0] bits_reg;
    logic open_reg;
    logic [5:0] round_reg;
    logic [1:0] out_cnt_reg;
    state_t state_reg, state_next;
    job_t job_reg;
    logic last_pending_reg;
    logic pad_second_reg;
    logic [7:0] byte_hold_reg;

    logic wr_en;
    logic [2:0] wr_idx;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign wr_idx = paddr[5:3];
    assign prdata = key_reg[paddr[5:3]];

    logic in_fire;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;

    // round unit
    word_t s0, s1, ch, maj, t1, t2, sig0, sig1, w_new, k_w;
    always_comb
    begin
        s1 = rotr(var_reg[4], 6) ^ rotr(var_reg[4], 11) ^ rotr(var_reg[4], 25);
        ch = (var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]);
        s0 = rotr(var_reg[0], 2) ^ rotr(var_reg[0], 13) ^ rotr(var_reg[0], 22);
        maj = (var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
            ^ (var_reg[1] & var_reg[2]);
        k_w = round_k(round_reg) + w_reg[0];
        t1 = var_reg[7] + s1 + ch + k_w;
        t2 = s0 + maj;
        sig0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sig1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + sig0 + w_reg[9] + sig1;
        for (int i = 0; i < 8; i++)
        begin
            hash_next[i] = hash_reg[i] + var_reg[i];
        end
    end

    // byte placement
    logic [1:0] lane;
    logic [3:0] widx;
    assign lane = fill_reg[1:0];
    assign widx = fill_reg[5:2];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_ch.byte_present || in_ch.message_end))
                begin
                    if (!open_reg)
                        state_next = ST_LOAD;
                    else if (in_ch.byte_present && fill_reg == 6'd63)
                        state_next = ST_LOAD;
                    else if (in_ch.message_end)
                        state_next = ST_PAD;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: state_next = (round_reg == 6'd63) ? ST_FINAL : ST_ROUND;
            ST_FINAL:
            begin
                case (job_reg)
                    JOB_IPAD:  state_next = ST_PAD;
                    JOB_DATA:  state_next = last_pending_reg ? ST_PAD : ST_IDLE;
                    JOB_PAD:   state_next = ST_LOAD;
                    JOB_OPAD:  state_next = ST_LOAD;
                    JOB_OUTER: state_next = ST_OUT;
                    default:   state_next = ST_IDLE;
                endcase
            end
            ST_PAD:   state_next = last_pending_reg ? ST_LOAD : ST_IDLE;
            ST_OUT:
            begin
                if (out_ch.ready && out_cnt_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_ch.valid = (state_reg == ST_OUT);
        out_ch.tag_word = {hash_reg[{out_cnt_reg, 1'b0}], hash_reg[{out_cnt_reg, 1'b1}]};
        out_ch.tag_last = (out_cnt_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KeyWords; i++) key_reg[i] <= '0;
            state_reg <= ST_IDLE;
            open_reg <= 1'b0;
            fill_reg <= '0;
            bits_reg <= '0;
            round_reg <= '0;
            out_cnt_reg <= '0;
            job_reg <= JOB_IPAD;
            last_pending_reg <= 1'b0;
            pad_second_reg <= 1'b0;
            byte_hold_reg <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
                key_reg[wr_idx] <= pwdata;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire && (in_ch.byte_present || in_ch.message_end))
                    begin
                        last_pending_reg <= in_ch.message_end;
                        if (!open_reg)
                        begin
                            // ipad block, byte is applied afterwards in ST_FINAL
                            open_reg <= 1'b1;
                            fill_reg <= '0;
                            bits_reg <= 64'd512;
                            job_reg <= JOB_IPAD;
                            for (int i = 0; i < 8; i++) hash_reg[i] <= init_h(3'(i));
                            for (int i = 0; i < 16; i++)
                                blk_reg[i] <= (i[0] ? key_reg[i/2][31:0]
                                                    : key_reg[i/2][63:32]) ^ IPAD;
                            pad_second_reg <= in_ch.byte_present;
                            byte_hold_reg <= in_ch.data_byte;
                        end
                        else if (in_ch.byte_present)
                        begin
                            if (lane == 2'd0)
                                blk_reg[widx] <= {in_ch.data_byte, 24'h0};
                            else
                                blk_reg[widx][8'(3 - lane) * 8 +: 8] <= in_ch.data_byte;
                            fill_reg <= fill_reg + 6'd1;
                            bits_reg <= bits_reg + 64'd8;
                            pad_second_reg <= 1'b0;
                            if (fill_reg == 6'd63)
                                job_reg <= JOB_DATA;
                        end
                        else
                        begin
                            pad_second_reg <= 1'b0;
                        end
                    end
                end
                ST_LOAD:
                begin
                    for (int i = 0; i < 8; i++) var_reg[i] <= hash_reg[i];
                    for (int i = 0; i < 16; i++) w_reg[i] <= blk_reg[i];
                    round_reg <= '0;
                end
                ST_ROUND:
                begin
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= w_new;
                    round_reg <= round_reg + 6'd1;
                end
                ST_FINAL:
                begin
                    // the last inner block hands over to a fresh outer hash
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= (job_reg == JOB_PAD && !pad_second_reg)
                                       ? init_h(3'(i)) : hash_next[i];
                    case (job_reg)
                        JOB_IPAD:
                        begin
                            // pad_second marks a byte carried with the opening item
                            if (pad_second_reg)
                            begin
                                blk_reg[0] <= {byte_hold_reg, 24'h0};
                                fill_reg <= 6'd1;
                                bits_reg <= bits_reg + 64'd8;
                            end
                            pad_second_reg <= 1'b0;
                        end
                        JOB_DATA:
                        begin
                            fill_reg <= '0;
                            pad_second_reg <= 1'b0;
                        end
                        JOB_PAD:
                        begin
                            if (pad_second_reg)
                            begin
                                for (int i = 0; i < 14; i++) blk_reg[i] <= '0;
                                blk_reg[14] <= bits_reg[63:32];
                                blk_reg[15] <= bits_reg[31:0];
                                pad_second_reg <= 1'b0;
                                job_reg <= JOB_PAD;
                            end
                            else
                            begin
                                for (int i = 0; i < 8; i++)
                                    inner_reg[i] <= hash_next[i];
                                for (int i = 0; i < 16; i++)
                                    blk_reg[i] <= (i[0] ? key_reg[i/2][31:0]
                                                        : key_reg[i/2][63:32]) ^ OPAD;
                                job_reg <= JOB_OPAD;
                            end
                        end
                        JOB_OPAD:
                        begin
                            for (int i = 0; i < 8; i++) blk_reg[i] <= inner_reg[i];
                            blk_reg[8] <= 32'h80000000;
                            for (int i = 9; i < 15; i++) blk_reg[i] <= '0;
                            blk_reg[15] <= 32'd768;
                            job_reg <= JOB_OUTER;
                        end
                        JOB_OUTER:
                        begin
                            out_cnt_reg <= '0;
                            open_reg <= 1'b0;
                            fill_reg <= '0;
                            bits_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_PAD:
                begin
                    // close the inner hash: 0x80, zeros, bit count (in a second pad block if fill >= 56)
                    if (last_pending_reg)
                    begin
                        for (int i = 0; i < 16; i++)
                        begin
                            if (6'(i) > widx)
                            begin
                                if (fill_reg < 6'd56 && i == 14)
                                    blk_reg[i] <= bits_reg[63:32];
                                else if (fill_reg < 6'd56 && i == 15)
                                    blk_reg[i] <= bits_reg[31:0];
                                else
                                    blk_reg[i] <= '0;
                            end
                        end
                        case (lane)
                            2'd0: blk_reg[widx] <= 32'h80000000;
                            2'd1: blk_reg[widx] <= {blk_reg[widx][31:24], 24'h800000};
                            2'd2: blk_reg[widx] <= {blk_reg[widx][31:16], 16'h8000};
                            2'd3: blk_reg[widx] <= {blk_reg[widx][31:8], 8'h80};
                            default: ;
                        endcase
                        pad_second_reg <= (fill_reg >= 6'd56);
                        job_reg <= JOB_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                        out_cnt_reg <= out_cnt_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !in_ch.ready)
        else $error("ready during compression");
    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg != 6'd63) |=> (state_reg == ST_ROUND))
        else $error("round sequence broken");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_cnt_reg)))
        else $error("tag word dropped under stall");
endmodule
`default_nettype wire

// ----- sim/hmac_sha256_stream_core_tb.sv -----
`timescale 1ns / 1ps
module hmac_sha256_stream_core_tb;
    import hmac_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       message_end;
    } msg_item_t;

    typedef struct packed {
        logic [63:0] tag_word;
        logic        tag_last;
    } tag_item_t;

    // directed row: item plus an optional hand-typed tag word 0
    typedef struct {
        msg_item_t   item;
        logic        has_known;
        logic [63:0] known_word0;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    hmac_in_if in_ch ();
    hmac_out_if out_ch ();

    hmac_sha256_stream_core dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // predictor state
    logic [63:0] key_regs [KeyWords];
    word_t       hv [8];
    word_t       blk [16];
    logic [5:0]  fill;
    logic [63:0] bit_count;
    logic        msg_open;

    tag_item_t expected_tags [$];
    int          n_errors;
    logic        stall_long;
    int          stall_cycles;
    logic        busy_idle_free;

    function automatic word_t ror(input word_t x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_compress(input word_t b [16]);
        word_t w [64];
        word_t v [8];
        word_t t1, t2;
        for (int i = 0; i < 16; i++) w[i] = b[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] = hv[i] + v[i];
    endtask

    task automatic keyed_start(input word_t pad);
        word_t b [16];
        for (int i = 0; i < 8; i++) hv[i] = init_h(i[2:0]);
        for (int i = 0; i < 16; i++)
            b[i] = ((i % 2) ? key_regs[i/2][31:0] : key_regs[i/2][63:32]) ^ pad;
        sha_compress(b);
    endtask

    task automatic append_byte(input logic [7:0] b);
        int idx;
        idx = fill;
        if (idx % 4 == 0) blk[idx/4] = '0;
        blk[idx/4] = blk[idx/4] | (word_t'(b) << ((3 - idx % 4) * 8));
        idx++;
        if (idx == 64)
        begin
            sha_compress(blk);
            idx = 0;
        end
        fill = idx[5:0];
    endtask

    task automatic predict_hmac(input msg_item_t it);
        word_t ob [16];
        word_t inner [8];
        tag_item_t t;
        if (!it.byte_present && !it.message_end) return;
        if (!msg_open)
        begin
            keyed_start(IPAD);
            fill = '0;
            bit_count = 64'd512;
            msg_open = 1'b1;
        end
        if (it.byte_present)
        begin
            append_byte(it.data_byte);
            bit_count = bit_count + 64'd8;
        end
        if (!it.message_end) return;
        append_byte(8'h80);
        while (fill != 6'd56) append_byte(8'h00);
        blk[14] = bit_count[63:32];
        blk[15] = bit_count[31:0];
        sha_compress(blk);
        for (int i = 0; i < 8; i++) inner[i] = hv[i];
        keyed_start(OPAD);
        for (int i = 0; i < 8; i++) ob[i] = inner[i];
        ob[8] = 32'h80000000;
        for (int i = 9; i < 15; i++) ob[i] = '0;
        ob[15] = 32'd768;
        sha_compress(ob);
        for (int k = 0; k < 4; k++)
        begin
            t.tag_word = {hv[2*k], hv[2*k+1]};
            t.tag_last = (k == 3);
            expected_tags.push_back(t);
        end
        fill = '0;
        bit_count = '0;
        msg_open = 1'b0;
    endtask

    task automatic apb_write(input int idx, input logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AddrWidth'(idx * 8); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx < KeyWords) key_regs[idx] = val;
    endtask

    // valid stays up after an accept so that the next item can follow at once
    task automatic send_item(input msg_item_t it);
        if (!busy_idle_free)
            while ($urandom_range(99) < 10)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= it.data_byte;
        in_ch.byte_present <= it.byte_present;
        in_ch.message_end <= it.message_end;
        do @(posedge clk); while (!in_ch.ready);
        predict_hmac(it);
    endtask

    task automatic drain_and_settle();
        in_ch.valid <= 1'b0;
        while (expected_tags.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // output side: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            if (stall_long && stall_cycles < 3000)
            begin
                stall_cycles <= stall_cycles + 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= busy_idle_free ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        tag_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_tags.size() == 0)
            begin
                $error("unexpected tag word %h", out_ch.tag_word);
                n_errors++;
            end
            else
            begin
                want = expected_tags.pop_front();
                if (want.tag_word !== out_ch.tag_word)
                begin
                    $error("tag_word expected %h actual %h", want.tag_word, out_ch.tag_word);
                    n_errors++;
                end
                if (want.tag_last !== out_ch.tag_last)
                begin
                    $error("tag_last expected %b actual %b", want.tag_last, out_ch.tag_last);
                    n_errors++;
                end
            end
        end
    end

    task automatic random_message(input int max_len);
        msg_item_t it;
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(130, 70) : $urandom_range(max_len);
        for (int i = 0; i < len; i++)
        begin
            it.data_byte = 8'($urandom_range(255));
            it.byte_present = ($urandom_range(9) != 0);
            it.message_end = 1'b0;
            send_item(it);
        end
        it.data_byte = 8'($urandom_range(255));
        it.byte_present = 1'($urandom_range(1));
        it.message_end = 1'b1;
        send_item(it);
    endtask

    stim_row_t rows [$];

    task automatic add_row(input logic [7:0] d, input logic p, input logic e,
                           input logic known, input logic [63:0] w0);
        stim_row_t r;
        r.item = '{data_byte: d, byte_present: p, message_end: e};
        r.has_known = known;
        r.known_word0 = w0;
        rows.push_back(r);
    endtask

    initial
    begin
        tag_item_t first;
        n_errors = 0;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.byte_present = 1'b0;
        in_ch.message_end = 1'b0;
        stall_long = 1'b0;
        busy_idle_free = 1'b0;
        for (int i = 0; i < KeyWords; i++) key_regs[i] = '0;
        for (int i = 0; i < 8; i++) hv[i] = init_h(i[2:0]);
        for (int i = 0; i < 16; i++) blk[i] = '0;
        fill = '0; bit_count = '0; msg_open = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty message with the all-zero key after reset: known hmac
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 64'hb613679a0814d9ec);
        add_row(8'h00, 1'b0, 1'b0, 1'b0, 64'h0);   // idle item
        add_row(8'hff, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(8'h00, 1'b1, 1'b0, 1'b0, 64'h0);
        add_row(8'ha5, 1'b0, 1'b0, 1'b0, 64'h0);
        add_row(8'h5a, 1'b1, 1'b1, 1'b0, 64'h0);   // byte on the closing item
        add_row(8'h01, 1'b1, 1'b1, 1'b0, 64'h0);   // one-byte message
        add_row(8'h80, 1'b0, 1'b1, 1'b0, 64'h0);
        for (int r = 0; r < rows.size(); r++)
        begin
            send_item(rows[r].item);
            if (rows[r].has_known)
            begin
                first = expected_tags[0];
                if (first.tag_word !== rows[r].known_word0)
                begin
                    $error("tag_word expected %h actual %h",
                           rows[r].known_word0, first.tag_word);
                    n_errors++;
                end
            end
        end
        drain_and_settle();

        // all-ones key, then message lengths around the block boundary and a full block
        for (int i = 0; i < KeyWords; i++) apb_write(i, '1);
        for (int len = 55; len <= 64; len += ((len == 55) ? 1 : 8))
        begin
            for (int i = 0; i < len; i++)
                send_item('{data_byte: 8'($urandom), byte_present: 1'b1, message_end: 1'b0});
            send_item('{data_byte: 8'h00, byte_present: 1'b0, message_end: 1'b1});
        end
        drain_and_settle();

        // random keys, including a short zero-padded one
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int i = 0; i < KeyWords; i++)
                apb_write(i, (phase == 1 && i > 2) ? 64'h0 : {$urandom, $urandom});
            if (phase == 1) busy_idle_free = 1'b1;
            if (phase == 2)
            begin
                busy_idle_free = 1'b0;
                stall_long = 1'b1;
            end
            for (int m = 0; m < 4; m++) random_message(6);
            drain_and_settle();
        end

        drain_and_settle();
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
